// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Bezier core, clocked with
// asynchronous active-low reset masking (disable iff).
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cbt_pkg.sv -----
// ---------------------------------------------------------------------------
// cbt_pkg
// Widths, register indexes and types shared by the Bezier core and its
// channel interfaces.
// ---------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

    localparam int COORD_WIDTH  = 16;               // signed Q12.4
    localparam int MAX_SEGMENTS = 63;
    localparam int SEG_WIDTH    = $clog2(MAX_SEGMENTS + 1);
    localparam int T_FRAC       = 16;               // t in unsigned Q1.16
    localparam int T_WIDTH      = T_FRAC + 1;
    localparam int T_ONE        = 1 << T_FRAC;
    localparam int N_CTRL       = 4;                // control points
    localparam int N_AXES       = 3;                // x, y, z

    // configuration port
    localparam int CFG_IDX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH = SEG_WIDTH;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SEGMENT_COUNT = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STROKE_ENABLE = 1'd1;

    localparam logic [SEG_WIDTH-1:0] SEG_COUNT_RESET = SEG_WIDTH'(20);
    localparam logic                 STROKE_RESET    = 1'b1;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

endpackage

`default_nettype wire

// ----- rtl/core/cbt_ifs.sv -----
// ---------------------------------------------------------------------------
// Bezier core channel interfaces
// Valid/ready channels for control-point items, curve points and
// configuration writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface cbt_item_if
    import cbt_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p0_x, p0_y, p0_z;
    logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z;
    logic signed [COORD_WIDTH-1:0] p3_x, p3_y, p3_z;

    modport source (
        output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        output ready
    );
endinterface

interface cbt_point_if
    import cbt_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x, point_y, point_z;
    logic                          last_point;

    modport source (
        output valid, point_x, point_y, point_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, last_point,
        output ready
    );
endinterface

interface cbt_cfg_if
    import cbt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_WIDTH-1:0]  index;
    logic [CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cubic_bezier_tessellator_core.sv -----
// ---------------------------------------------------------------------------
// cubic_bezier_tessellator_core
// Cubic Bezier evaluator: four 3D control points in, segment_count + 1
// curve points out through a six-register pipeline.
// ---------------------------------------------------------------------------
// Each control-point transaction produces n + 1 points, n = segment_count
// (0 reads as 1), at t_i = floor(i * 65536 / n) in Q1.16, i = 0..n; the
// final point has t = 1.0 and carries last_point. Each coordinate is
// sum(B_k(t) * P_k) with Bernstein weights kept at full Q.48 width, rounded
// to nearest (ties up) and saturated to 16 bits. The sequencer issues one
// point per cycle while the output is not stalled; the next curve is taken
// in the cycle its final point issues, so curves follow with no gap.
// An issued point passes stages S1 to S5 and then the output register.
// With stroke_enable low a transaction is taken and produces nothing.
// Output back-pressure stalls
// the whole pipeline and the sequencer. Configuration writes are taken at
// any time (ready is tied high) and must be made only while the core is
// idle. No clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_tessellator_core
    import cbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbt_cfg_if.sink     i_cfg,
    cbt_item_if.sink    i_item,
    cbt_point_if.source o_point
);

    // Weight arithmetic widths. u^2, t^2 <= 2^32; every weight <= 2^48.
    localparam int SQ_W    = 2 * T_FRAC + 1;
    localparam int W_FRAC  = 3 * T_FRAC;
    localparam int W_W     = W_FRAC + 1;
    localparam int LO_BITS = W_FRAC / 2;            // weight split point
    localparam int HI_BITS = W_W - LO_BITS;
    localparam int HI_W    = COORD_WIDTH + HI_BITS + 1;
    localparam int LO_W    = COORD_WIDTH + LO_BITS + 1;
    localparam int HS_W    = HI_W + 2;              // sum of four
    localparam int LS_W    = LO_W + 2;
    localparam int TOT_W   = COORD_WIDTH + W_W + 1;
    localparam int RND_W   = TOT_W - W_FRAC;
    localparam int SEG_VALS = 1 << SEG_WIDTH;
    localparam int COORD_MAX = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_WIDTH - 1));

    localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(COORD_MAX);
    localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(COORD_MIN);
    localparam logic signed [TOT_W-1:0] RND_HALF = TOT_W'(1) <<< (W_FRAC - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SEG_WIDTH-1:0] r_seg_count;
    logic                 r_stroke;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= SEG_COUNT_RESET;
            r_stroke    <= STROKE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SEGMENT_COUNT: r_seg_count <= i_cfg.data;
                CFG_STROKE_ENABLE: r_stroke    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Step table: t advances by floor(65536/n) plus a carry from the
    // remainder 65536 mod n, so t_i = floor(i*65536/n) with no divider.
    // ------------------------------------------------------------------
    logic [T_WIDTH-1:0]   w_step_q_tab [SEG_VALS];
    logic [SEG_WIDTH-1:0] w_step_r_tab [SEG_VALS];

    for (genvar g = 0; g < SEG_VALS; g++) begin : g_step_tab
        localparam int DIV = (g == 0) ? 1 : g;
        localparam logic [T_WIDTH-1:0]   QV = T_WIDTH'(T_ONE / DIV);
        localparam logic [SEG_WIDTH-1:0] RV = SEG_WIDTH'(T_ONE % DIV);
        assign w_step_q_tab[g] = QV;
        assign w_step_r_tab[g] = RV;
    end

    // ------------------------------------------------------------------
    // Sequencer: holds the control points and walks t over the curve
    // ------------------------------------------------------------------
    t_seq_state r_state, n_state;
    logic [SEG_WIDTH-1:0] r_idx, n_idx;
    logic [SEG_WIDTH-1:0] r_n;
    logic [T_WIDTH-1:0]   r_step_q;
    logic [SEG_WIDTH-1:0] r_step_r;
    logic [T_WIDTH-1:0]   r_t_acc, n_t_acc;
    logic [SEG_WIDTH-1:0] r_rem, n_rem;
    logic signed [COORD_WIDTH-1:0] r_p [N_CTRL][N_AXES];

    logic [SEG_WIDTH-1:0] w_load_n;
    logic [SEG_WIDTH:0]   w_rem_sum;
    logic                 w_carry;
    logic                 w_load;
    logic                 w_in_ready;
    logic                 w_issue_valid;
    logic                 w_issue_last;
    logic                 w_adv;

    assign w_load_n  = (r_seg_count == '0) ? SEG_WIDTH'(1) : r_seg_count;
    assign w_rem_sum = {1'b0, r_rem} + {1'b0, r_step_r};
    assign w_carry   = (w_rem_sum >= {1'b0, r_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_idx   <= '0;
            r_t_acc <= '0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_t_acc <= n_t_acc;
            r_rem   <= n_rem;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_t_acc       = r_t_acc;
        n_rem         = r_rem;
        w_load        = 1'b0;
        w_in_ready    = 1'b0;
        w_issue_valid = 1'b0;
        w_issue_last  = (r_idx == r_n);
        unique case (r_state)
            SEQ_IDLE: begin
                w_in_ready = 1'b1;
                if (i_item.valid && r_stroke) begin
                    w_load  = 1'b1;
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                w_issue_valid = 1'b1;
                if (w_adv) begin
                    if (w_issue_last) begin
                        // final point leaves: take the next curve now
                        w_in_ready = 1'b1;
                        n_state    = SEQ_IDLE;
                        if (i_item.valid && r_stroke) begin
                            w_load  = 1'b1;
                            n_state = SEQ_RUN;
                        end
                    end else begin
                        n_idx   = r_idx + SEG_WIDTH'(1);
                        n_t_acc = r_t_acc + r_step_q + T_WIDTH'(w_carry);
                        n_rem   = w_carry ? SEG_WIDTH'(w_rem_sum - {1'b0, r_n})
                                          : w_rem_sum[SEG_WIDTH-1:0];
                    end
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
        if (w_load) begin
            n_idx   = '0;
            n_t_acc = '0;
            n_rem   = '0;
        end
    end

    assign i_item.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_n         <= w_load_n;
            r_step_q    <= w_step_q_tab[w_load_n];
            r_step_r    <= w_step_r_tab[w_load_n];
            r_p[0][0] <= i_item.p0_x; r_p[0][1] <= i_item.p0_y; r_p[0][2] <= i_item.p0_z;
            r_p[1][0] <= i_item.p1_x; r_p[1][1] <= i_item.p1_y; r_p[1][2] <= i_item.p1_z;
            r_p[2][0] <= i_item.p2_x; r_p[2][1] <= i_item.p2_y; r_p[2][2] <= i_item.p2_z;
            r_p[3][0] <= i_item.p3_x; r_p[3][1] <= i_item.p3_y; r_p[3][2] <= i_item.p3_z;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline. All stages move together when the output register can
    // take a point; valid bits travel with the data.
    // ------------------------------------------------------------------
    logic r_out_valid;
    assign w_adv = !r_out_valid || o_point.ready;

    // S1: u = 1 - t, then u^2 and t^2
    logic                          r_s1_valid, r_s1_last;
    logic [T_WIDTH-1:0]            r_s1_t, r_s1_u;
    logic [SQ_W-1:0]               r_s1_uu, r_s1_tt;
    logic signed [COORD_WIDTH-1:0] r_s1_p [N_CTRL][N_AXES];
    logic [T_WIDTH-1:0]            w_u;

    assign w_u = T_WIDTH'(T_ONE) - r_t_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_issue_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_last <= w_issue_last;
            r_s1_t    <= r_t_acc;
            r_s1_u    <= w_u;
            r_s1_uu   <= SQ_W'(w_u) * SQ_W'(w_u);
            r_s1_tt   <= SQ_W'(r_t_acc) * SQ_W'(r_t_acc);
            r_s1_p    <= r_p;
        end
    end

    // S2: raw cubic terms u^3, u^2 t, u t^2, t^3
    logic                          r_s2_valid, r_s2_last;
    logic [W_W-1:0]                r_s2_m [N_CTRL];
    logic signed [COORD_WIDTH-1:0] r_s2_p [N_CTRL][N_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_last <= r_s1_last;
            r_s2_m[0] <= W_W'(r_s1_uu) * W_W'(r_s1_u);
            r_s2_m[1] <= W_W'(r_s1_uu) * W_W'(r_s1_t);
            r_s2_m[2] <= W_W'(r_s1_tt) * W_W'(r_s1_u);
            r_s2_m[3] <= W_W'(r_s1_tt) * W_W'(r_s1_t);
            r_s2_p    <= r_s1_p;
        end
    end

    // S3: Bernstein weights (inner terms times 3)
    logic                          r_s3_valid, r_s3_last;
    logic [W_W-1:0]                r_s3_w [N_CTRL];
    logic signed [COORD_WIDTH-1:0] r_s3_p [N_CTRL][N_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_last <= r_s2_last;
            r_s3_w[0] <= r_s2_m[0];
            r_s3_w[1] <= (r_s2_m[1] << 1) + r_s2_m[1];
            r_s3_w[2] <= (r_s2_m[2] << 1) + r_s2_m[2];
            r_s3_w[3] <= r_s2_m[3];
            r_s3_p    <= r_s2_p;
        end
    end

    // S4: coordinate times weight, weight split in high and low halves
    logic                        r_s4_valid, r_s4_last;
    logic signed [HI_W-1:0]      r_s4_hi [N_AXES][N_CTRL];
    logic signed [LO_W-1:0]      r_s4_lo [N_AXES][N_CTRL];
    logic signed [HI_W-1:0]      w_hi_prod [N_AXES][N_CTRL];
    logic signed [LO_W-1:0]      w_lo_prod [N_AXES][N_CTRL];

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            for (int k = 0; k < N_CTRL; k++) begin
                w_hi_prod[a][k] = HI_W'(r_s3_p[k][a])
                    * HI_W'($signed({1'b0, r_s3_w[k][W_W-1:LO_BITS]}));
                w_lo_prod[a][k] = LO_W'(r_s3_p[k][a])
                    * LO_W'($signed({1'b0, r_s3_w[k][LO_BITS-1:0]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_last <= r_s3_last;
            r_s4_hi   <= w_hi_prod;
            r_s4_lo   <= w_lo_prod;
        end
    end

    // S5: sum the four control-point terms per axis
    logic                   r_s5_valid, r_s5_last;
    logic signed [HS_W-1:0] r_s5_hi [N_AXES];
    logic signed [LS_W-1:0] r_s5_lo [N_AXES];
    logic signed [HS_W-1:0] w_hi_sum [N_AXES];
    logic signed [LS_W-1:0] w_lo_sum [N_AXES];

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            w_hi_sum[a] = HS_W'(r_s4_hi[a][0]) + HS_W'(r_s4_hi[a][1])
                        + HS_W'(r_s4_hi[a][2]) + HS_W'(r_s4_hi[a][3]);
            w_lo_sum[a] = LS_W'(r_s4_lo[a][0]) + LS_W'(r_s4_lo[a][1])
                        + LS_W'(r_s4_lo[a][2]) + LS_W'(r_s4_lo[a][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_adv) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_last <= r_s4_last;
            r_s5_hi   <= w_hi_sum;
            r_s5_lo   <= w_lo_sum;
        end
    end

    // S6: recombine, round half up, drop the Q.48 fraction, saturate
    logic signed [TOT_W-1:0]       w_total [N_AXES];
    logic signed [RND_W-1:0]       w_rnd   [N_AXES];
    logic signed [COORD_WIDTH-1:0] w_sat   [N_AXES];

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            w_total[a] = (TOT_W'(r_s5_hi[a]) <<< LO_BITS) + TOT_W'(r_s5_lo[a]) + RND_HALF;
            w_rnd[a]   = w_total[a][TOT_W-1:W_FRAC];
            if (w_rnd[a] > RND_MAX) begin
                w_sat[a] = COORD_WIDTH'(RND_MAX);
            end else if (w_rnd[a] < RND_MIN) begin
                w_sat[a] = COORD_WIDTH'(RND_MIN);
            end else begin
                w_sat[a] = COORD_WIDTH'(w_rnd[a]);
            end
        end
    end

    logic signed [COORD_WIDTH-1:0] r_out_pt [N_AXES];
    logic                          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pt   <= w_sat;
            r_out_last <= r_s5_last;
        end
    end

    assign o_point.valid      = r_out_valid;
    assign o_point.point_x    = r_out_pt[0];
    assign o_point.point_y    = r_out_pt[1];
    assign o_point.point_z    = r_out_pt[2];
    assign o_point.last_point = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    // a new curve only enters when idle or as the old one's final point issues
    `CBT_ASSERT_IMP(a_accept_at_end, i_clk, i_rst_n, i_item.valid && i_item.ready, (r_state == SEQ_IDLE) || (w_issue_last && w_adv), "curve accepted mid-run")
    // the step accumulator lands exactly on t = 1.0 at the final point
    `CBT_ASSERT_IMP(a_final_t_one, i_clk, i_rst_n, (r_state == SEQ_RUN) && (r_idx == r_n), r_t_acc == T_WIDTH'(T_ONE), "final t is not one")
    // step remainder stays below the segment count, index never passes it
    `CBT_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, r_state == SEQ_RUN, (r_rem < r_n) && (r_idx <= r_n), "step remainder or index out of range")
    // with stroke off an accepted curve starts no run
    `CBT_ASSERT_NXT(a_stroke_off, i_clk, i_rst_n, i_item.valid && i_item.ready && !r_stroke && (r_state == SEQ_IDLE), r_state == SEQ_IDLE, "run started with stroke disabled")

endmodule

`default_nettype wire

// ----- tb/cubic_bezier_tessellator_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_bezier_tessellator_core_tb
// Self-checking bench for the cubic Bezier core. Control-point sets go in
// through the item channel and each accepted set is expanded into its curve
// points by a fixed-point Bernstein evaluator kept in the bench. Points that
// leave the core are matched in order against that list. The run walks
// through several segment_count / stroke_enable settings with random gaps
// on the sender and random back-pressure on the receiver.
// ---------------------------------------------------------------------------

module cubic_bezier_tessellator_core_tb;
    import cbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 12;    // pipeline drain margin
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_CURVES  = 340;   // random control-point sets
    localparam int MAX_REPORTS    = 40;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // p[k][a]: control point k (0..3), axis a (0 = x, 1 = y, 2 = z)
    typedef struct {
        t_coord p [N_CTRL][N_AXES];
    } t_curve_ctrl;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
    } t_curve_point;

    localparam t_coord C_MAX = 16'sh7fff;
    localparam t_coord C_MIN = 16'sh8000;

    // -----------------------------------------------------------------------
    // Curve point tracker: evaluates each accepted control-point set into
    // its curve points and matches the core's output against them in order.
    // -----------------------------------------------------------------------
    class curve_point_tracker;
        logic [SEG_WIDTH-1:0] seg_count = SEG_COUNT_RESET;
        logic                 stroke_on = STROKE_RESET;
        t_curve_point         pending_points [$];
        int                   mismatches;

        function void write_register(logic [CFG_IDX_WIDTH-1:0] idx,
                                     logic [CFG_DATA_WIDTH-1:0] data);
            if (idx == CFG_SEGMENT_COUNT)
                seg_count = data[SEG_WIDTH-1:0];
            else if (idx == CFG_STROKE_ENABLE)
                stroke_on = data[0];
        endfunction

        // sum(w_k * P_k) over Q.48 weights, round half up, saturate
        function t_coord blend(t_curve_ctrl cs, int axis,
                               logic signed [79:0] w [N_CTRL]);
            logic signed [79:0] acc;
            logic signed [79:0] pk;
            logic signed [79:0] half;
            longint             v;
            longint             vmax;
            acc  = '0;
            half = 80'sd1 <<< 47;
            vmax = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
            for (int k = 0; k < N_CTRL; k++) begin
                pk  = cs.p[k][axis];
                acc = acc + pk * w[k];
            end
            v = longint'((acc + half) >>> 48);
            if (v > vmax)
                v = vmax;
            if (v < -vmax - 1)
                v = -vmax - 1;
            return t_coord'(v);
        endfunction

        function void take_curve(t_curve_ctrl cs);
            longint             n;
            longint             t;
            longint             u;
            logic signed [79:0] w [N_CTRL];
            t_curve_point       pt;
            if (!stroke_on)
                return;
            // zero segments reads as one
            n = (seg_count == 0) ? 1 : seg_count;
            for (longint i = 0; i <= n; i++) begin
                t    = (i * T_ONE) / n;
                u    = T_ONE - t;
                w[0] = u * u * u;
                w[1] = 3 * u * u * t;
                w[2] = 3 * u * t * t;
                w[3] = t * t * t;
                pt.x    = blend(cs, 0, w);
                pt.y    = blend(cs, 1, w);
                pt.z    = blend(cs, 2, w);
                pt.last = (i == n);
                pending_points.push_back(pt);
            end
        endfunction

        function void flag(string name, longint want, longint got);
            if (want == got)
                return;
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", name, want, got);
        endfunction

        function void match_point(t_curve_point got);
            t_curve_point want;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("point_x: expected none, actual %0d (unexpected point)", got.x);
                return;
            end
            want = pending_points.pop_front();
            flag("point_x", want.x, got.x);
            flag("point_y", want.y, got.y);
            flag("point_z", want.z, got.z);
            flag("last_point", want.last, got.last);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cbt_cfg_if   cfg_ch ();
    cbt_item_if  item_ch ();
    cbt_point_if point_ch ();

    curve_point_tracker curve_points = new();

    bit item_burst;     // phase without sender gaps
    int stall_cycles;

    cubic_bezier_tessellator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_item  (item_ch),
        .o_point (point_ch)
    );

    always #4 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Monitor: every transaction is sampled at the rising edge, on values
    // that were settled before it.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_curve_ctrl  cs;
        t_curve_point pt;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                curve_points.write_register(cfg_ch.index, cfg_ch.data);
            if (item_ch.valid && item_ch.ready) begin
                cs.p[0] = '{item_ch.p0_x, item_ch.p0_y, item_ch.p0_z};
                cs.p[1] = '{item_ch.p1_x, item_ch.p1_y, item_ch.p1_z};
                cs.p[2] = '{item_ch.p2_x, item_ch.p2_y, item_ch.p2_z};
                cs.p[3] = '{item_ch.p3_x, item_ch.p3_y, item_ch.p3_z};
                curve_points.take_curve(cs);
            end
            if (point_ch.valid && point_ch.ready) begin
                pt.x    = point_ch.point_x;
                pt.y    = point_ch.point_y;
                pt.z    = point_ch.point_z;
                pt.last = point_ch.last_point;
                curve_points.match_point(pt);
            end
        end
    end

    // Watchdog: too long without any transaction means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready)
                || (point_ch.valid && point_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver pacing: mostly short ready/stall runs, a few long stalls and
    // long stretches with ready held high.
    // -----------------------------------------------------------------------
    initial begin
        int hold;
        int r;
        hold = 0;
        point_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    point_ch.ready <= 1'b1;
                    hold = $urandom_range(0, 20);
                end else if (r < 80) begin
                    point_ch.ready <= 1'b0;
                    hold = $urandom_range(0, 2);
                end else if (r < 93) begin
                    point_ch.ready <= 1'b1;
                    hold = $urandom_range(40, 150);
                end else begin
                    point_ch.ready <= 1'b0;
                    hold = $urandom_range(8, 40);
                end
            end
        end
    end

    // Sender gap before the next control-point transaction.
    function automatic int pick_gap();
        int r;
        if (item_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a rising edge; returns at the edge where the set is taken,
    // with valid still high so the next set can follow with no gap.
    task automatic send_curve(input t_curve_ctrl cs);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.p0_x  <= cs.p[0][0];
        item_ch.p0_y  <= cs.p[0][1];
        item_ch.p0_z  <= cs.p[0][2];
        item_ch.p1_x  <= cs.p[1][0];
        item_ch.p1_y  <= cs.p[1][1];
        item_ch.p1_z  <= cs.p[1][2];
        item_ch.p2_x  <= cs.p[2][0];
        item_ch.p2_y  <= cs.p[2][1];
        item_ch.p2_z  <= cs.p[2][2];
        item_ch.p3_x  <= cs.p[3][0];
        item_ch.p3_y  <= cs.p[3][1];
        item_ch.p3_z  <= cs.p[3][2];
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Drain, let a stroke-off set still in flight clear the pipeline, then
    // write both registers back to back. The task first waits for an edge so the
    // monitor has logged the last accepted set before the queue is polled.
    task automatic apply_settings(input logic [SEG_WIDTH-1:0] seg, input logic stroke);
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (curve_points.pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_SEGMENT_COUNT;
        cfg_ch.data  <= CFG_DATA_WIDTH'(seg);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        // upper data bits are don't-care for stroke_enable; keep them noisy
        cfg_ch.index <= CFG_STROKE_ENABLE;
        cfg_ch.data  <= CFG_DATA_WIDTH'({$urandom_range(0, 31), stroke});
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_curve_ctrl directed_curve(int k);
        t_curve_ctrl cs;
        for (int a = 0; a < N_CTRL; a++)
            cs.p[a] = '{16'sd0, 16'sd0, 16'sd0};
        case (k)
            1: begin
                for (int a = 0; a < N_CTRL; a++)
                    cs.p[a] = '{C_MAX, C_MAX, C_MAX};
            end
            2: begin
                for (int a = 0; a < N_CTRL; a++)
                    cs.p[a] = '{C_MIN, C_MIN, C_MIN};
            end
            3: begin
                // full-swing zigzag on x and y, a single full-swing step on z
                cs.p[0] = '{C_MAX, C_MIN, C_MAX};
                cs.p[1] = '{C_MIN, C_MAX, C_MAX};
                cs.p[2] = '{C_MAX, C_MIN, C_MIN};
                cs.p[3] = '{C_MIN, C_MAX, C_MIN};
            end
            4: begin
                cs.p[0] = '{16'sh5555, 16'shaaaa, 16'sh5555};
                cs.p[1] = '{16'shaaaa, 16'sh5555, 16'shaaaa};
                cs.p[2] = '{16'sh5555, 16'shaaaa, 16'sh5555};
                cs.p[3] = '{16'shaaaa, 16'sh5555, 16'shaaaa};
            end
            5: begin
                // flat 2D curve, z stays zero
                cs.p[0] = '{-16'sd1000, -16'sd2000, 16'sd0};
                cs.p[1] = '{16'sd3000, -16'sd500, 16'sd0};
                cs.p[2] = '{-16'sd3000, 16'sd500, 16'sd0};
                cs.p[3] = '{16'sd1000, 16'sd2000, 16'sd0};
            end
            6: begin
                // single LSB at the end anchor: rounding near zero
                cs.p[3] = '{16'sd1, -16'sd1, 16'sd1};
            end
            7: begin
                cs.p[0] = '{-16'sd1, 16'sd0, 16'sd1};
                cs.p[1] = '{16'sd1, -16'sd1, 16'sd3};
                cs.p[2] = '{-16'sd3, 16'sd2, 16'sd1};
                cs.p[3] = '{16'sd0, 16'sd1, -16'sd2};
            end
            default: ;
        endcase
        return cs;
    endfunction

    function automatic t_coord random_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return C_MAX;
        if (r == 1)
            return C_MIN;
        if (r == 2)
            return t_coord'($urandom_range(0, 63)) - 16'sd32;
        return t_coord'($urandom);
    endfunction

    function automatic t_curve_ctrl random_curve();
        t_curve_ctrl cs;
        bit          flat;
        flat = ($urandom_range(0, 9) == 0);    // 2D curve now and then
        for (int k = 0; k < N_CTRL; k++)
            for (int a = 0; a < N_AXES; a++)
                cs.p[k][a] = (flat && a == 2) ? 16'sd0 : random_coord();
        return cs;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        int                   counted;
        int                   n_items;
        int                   r;
        logic [SEG_WIDTH-1:0] seg;
        logic                 stroke;

        i_rst_n       <= 1'b0;
        item_burst     = 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_SEGMENT_COUNT;
        cfg_ch.data   <= '0;
        item_ch.valid <= 1'b0;
        item_ch.p0_x  <= '0;
        item_ch.p0_y  <= '0;
        item_ch.p0_z  <= '0;
        item_ch.p1_x  <= '0;
        item_ch.p1_y  <= '0;
        item_ch.p1_z  <= '0;
        item_ch.p2_x  <= '0;
        item_ch.p2_y  <= '0;
        item_ch.p2_z  <= '0;
        item_ch.p3_x  <= '0;
        item_ch.p3_y  <= '0;
        item_ch.p3_z  <= '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings first (20 segments, stroke on)
        for (int k = 0; k < 8; k++)
            send_curve(directed_curve(k));

        // zero segment count behaves as one segment
        apply_settings(6'd0, 1'b1);
        for (int k = 0; k < 3; k++)
            send_curve(directed_curve(k));

        // largest curve
        apply_settings(6'(MAX_SEGMENTS), 1'b1);
        for (int k = 3; k < 6; k++)
            send_curve(directed_curve(k));

        // stroke off: transactions taken, nothing comes out
        apply_settings(6'd1, 1'b0);
        for (int k = 0; k < 2; k++)
            send_curve(directed_curve(k));

        apply_settings(6'd1, 1'b1);
        for (int k = 6; k < 8; k++)
            send_curve(directed_curve(k));

        // Random phases
        counted = 0;
        while (counted < RANDOM_CURVES) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                seg = 6'd0;
            else if (r < 20)
                seg = 6'(MAX_SEGMENTS);
            else if (r < 25)
                seg = 6'd1;
            else if (r < 55)
                seg = 6'($urandom_range(1, 6));
            else
                seg = 6'($urandom_range(1, MAX_SEGMENTS));
            stroke = ($urandom_range(0, 99) >= 15);
            apply_settings(seg, stroke);
            item_burst = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(8, 30);
            for (int j = 0; j < n_items; j++) begin
                send_curve(random_curve());
                counted++;
            end
        end

        // Wind down: wait for every point, then a little longer for strays
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (curve_points.pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (curve_points.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
